### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RTA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define RTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also holds across reset
`define RTA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/rta_pkg.sv
// types and constants of the region table allocator
package rta_pkg;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_CHECK   = 2'd2;

    localparam logic REG_POOL_BASE  = 1'b0;
    localparam logic REG_POOL_BYTES = 1'b1;

    localparam int PAGE_CNT_W = 21;
    localparam int ADDR_W     = 32;
    localparam int PADDR_W    = 3;

    typedef struct packed {
        logic [PAGE_CNT_W-1:0] pages;
        logic [ADDR_W-1:0]     start;
    } t_entry;

    typedef struct packed {
        logic [ADDR_W-1:0]     region_start;
        logic                  success;
        logic [ADDR_W-1:0]     freed_base;
        logic [PAGE_CNT_W-1:0] freed_pages;
    } t_result;

endpackage

### src/rta_if.sv
// request and response channel interfaces
interface rta_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] request_bytes;
    logic [31:0] query_address;

    modport source (output valid, kind, request_bytes, query_address, input ready);
    modport sink (input valid, kind, request_bytes, query_address, output ready);
endinterface

interface rta_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] region_start;
    logic        success;
    logic [31:0] freed_base;
    logic [20:0] freed_pages;

    modport source (output valid, region_start, success, freed_base, freed_pages, input ready);
    modport sink (input valid, region_start, success, freed_base, freed_pages, output ready);
endinterface

### src/region_table_allocator.sv
// region table allocator: allocate runs S_ALLOC_A then S_ALLOC_B; refused early, it goes to S_DONE
// release scans the table in S_REL and, on a match, compacts the entries above it in S_SHIFT
// check goes to S_DONE directly in the first pool page, else scans in S_CHK, one table read per cycle
// one item in flight; the next item is taken the cycle after its result is loaded
// synchronous active-low reset clears region count, pool registers and control state
// entry memory is not cleared, only entries below the count are used; PAGE_BYTES a power of 2
module region_table_allocator #(
    parameter int PAGE_BYTES  = 4096,
    parameter int MAX_REGIONS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rta_req_if.sink                       i_req,
    rta_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rta_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int IW     = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW     = $clog2(MAX_REGIONS + 1);
    localparam int PB_LOG = $clog2(PAGE_BYTES);
    localparam int SPAN_W = rta_pkg::PAGE_CNT_W + PB_LOG;
    localparam int EW     = ((SPAN_W > rta_pkg::ADDR_W) ? SPAN_W : rta_pkg::ADDR_W) + 2;
    localparam int NW     = rta_pkg::ADDR_W + 1;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b000_0001,
        S_ALLOC_A = 7'b000_0010,
        S_ALLOC_B = 7'b000_0100,
        S_REL     = 7'b000_1000,
        S_SHIFT   = 7'b001_0000,
        S_CHK     = 7'b010_0000,
        S_DONE    = 7'b100_0000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic r_cmp_valid, n_cmp_valid;
    logic [IW-1:0] r_cmp_idx, n_cmp_idx;
    logic r_hit_valid, n_hit_valid;
    logic r_hit, n_hit;
    logic [31:0] r_addr, n_addr;
    logic [NW-1:0] r_quo, n_quo;
    logic [EW-1:0] r_begin, n_begin;
    logic [EW-1:0] r_span, n_span;
    logic r_pg_ovf, n_pg_ovf;
    rta_pkg::t_result r_res, n_res;
    rta_pkg::t_result r_out, n_out;
    logic r_out_valid, n_out_valid;
    logic [31:0] r_pool_base, r_pool_bytes;

    rta_pkg::t_entry r_mem [MAX_REGIONS];
    rta_pkg::t_entry r_rd;
    logic w_rd_en, w_wr_en;
    logic [IW-1:0] w_rd_idx, w_wr_idx;
    rta_pkg::t_entry w_wr_data;

    logic [CW-1:0] w_count_m1, w_ptr_m1;
    logic [EW-1:0] w_rd_span, w_rd_end, w_alloc_end, w_limit, w_first_end;
    logic [NW-1:0] w_round;
    logic w_hit, w_match, w_first_page, w_fail, w_cfg_wr;

    assign w_count_m1  = r_count - CW'(1);
    assign w_ptr_m1    = r_ptr - CW'(1);
    assign w_rd_span   = EW'(r_rd.pages) * EW'(PAGE_BYTES);
    assign w_rd_end    = EW'(r_rd.start) + w_rd_span;
    assign w_hit       = (r_addr >= r_rd.start) && (EW'(r_addr) < w_rd_end);
    assign w_match     = r_cmp_valid && (r_rd.start == r_addr);
    assign w_round     = NW'(i_req.request_bytes) + NW'(PAGE_BYTES - 1);
    assign w_alloc_end = r_begin + r_span;
    assign w_limit     = EW'(r_pool_base) + EW'(r_pool_bytes);
    assign w_first_end = EW'(r_pool_base) + EW'(PAGE_BYTES);
    assign w_first_page = (i_req.query_address >= r_pool_base) &&
                          (EW'(i_req.query_address) < w_first_end);
    assign w_fail = r_pg_ovf || (w_alloc_end > w_limit) ||
                    (w_alloc_end > (EW'(1) << rta_pkg::ADDR_W));

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.region_start = r_out.region_start;
    assign o_rsp.success      = r_out.success;
    assign o_rsp.freed_base   = r_out.freed_base;
    assign o_rsp.freed_pages  = r_out.freed_pages;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == rta_pkg::REG_POOL_BYTES) ? r_pool_bytes : r_pool_base;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_hit_valid = r_hit_valid;
        n_hit       = r_hit;
        n_addr      = r_addr;
        n_quo       = r_quo;
        n_begin     = r_begin;
        n_span      = r_span;
        n_pg_ovf    = r_pg_ovf;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        w_rd_en     = 1'b0;
        w_rd_idx    = r_ptr[IW-1:0];
        w_wr_en     = 1'b0;
        w_wr_idx    = r_cmp_idx;
        w_wr_data   = r_rd;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res       = '0;
                    n_addr      = i_req.query_address;
                    n_ptr       = '0;
                    n_cmp_valid = 1'b0;
                    n_hit_valid = 1'b0;
                    case (i_req.kind)
                        rta_pkg::KIND_ALLOC: begin
                            if (i_req.request_bytes == 32'd0 ||
                                r_count >= CW'(MAX_REGIONS)) begin
                                n_state = S_DONE;
                            end else begin
                                w_rd_en  = 1'b1;
                                w_rd_idx = w_count_m1[IW-1:0];
                                n_quo    = w_round >> PB_LOG;
                                n_state  = S_ALLOC_A;
                            end
                        end
                        rta_pkg::KIND_RELEASE: begin
                            n_state = S_REL;
                        end
                        rta_pkg::KIND_CHECK: begin
                            if (w_first_page) begin
                                n_res.success = 1'b1;
                                n_state       = S_DONE;
                            end else begin
                                n_state = S_CHK;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC_A: begin
                n_begin  = (r_count == '0) ? w_first_end : w_rd_end;
                n_span   = EW'(r_quo[rta_pkg::PAGE_CNT_W-1:0]) * EW'(PAGE_BYTES);
                n_pg_ovf = |r_quo[NW-1:rta_pkg::PAGE_CNT_W];
                n_state  = S_ALLOC_B;
            end
            S_ALLOC_B: begin
                if (!w_fail) begin
                    w_wr_en            = 1'b1;
                    w_wr_idx           = r_count[IW-1:0];
                    w_wr_data.start    = r_begin[rta_pkg::ADDR_W-1:0];
                    w_wr_data.pages    = r_quo[rta_pkg::PAGE_CNT_W-1:0];
                    n_count            = r_count + CW'(1);
                    n_res.region_start = r_begin[rta_pkg::ADDR_W-1:0];
                    n_res.success      = (r_begin[rta_pkg::ADDR_W-1:0] != '0);
                end
                n_state = S_DONE;
            end
            S_REL: begin
                if (w_match) begin
                    n_res.success     = 1'b1;
                    n_res.freed_base  = r_rd.start;
                    n_res.freed_pages = r_rd.pages;
                    n_ptr             = CW'(r_cmp_idx) + CW'(1);
                    n_cmp_valid       = 1'b0;
                    n_state           = S_SHIFT;
                end else if (r_ptr < r_count) begin
                    w_rd_en     = 1'b1;
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_ptr[IW-1:0];
                    n_ptr       = r_ptr + CW'(1);
                end else begin
                    n_cmp_valid = 1'b0;
                    n_state     = S_DONE;
                end
            end
            S_SHIFT: begin
                w_wr_en = r_cmp_valid;
                if (r_ptr < r_count) begin
                    w_rd_en     = 1'b1;
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = w_ptr_m1[IW-1:0];
                    n_ptr       = r_ptr + CW'(1);
                end else begin
                    n_cmp_valid = 1'b0;
                    if (!r_cmp_valid) begin
                        n_count = w_count_m1;
                        n_state = S_DONE;
                    end
                end
            end
            S_CHK: begin
                n_hit_valid = r_cmp_valid;
                n_hit       = w_hit;
                if (r_hit_valid && r_hit) begin
                    n_res.success = 1'b1;
                    n_cmp_valid   = 1'b0;
                    n_hit_valid   = 1'b0;
                    n_state       = S_DONE;
                end else if (r_ptr < r_count) begin
                    w_rd_en     = 1'b1;
                    n_cmp_valid = 1'b1;
                    n_ptr       = r_ptr + CW'(1);
                end else begin
                    n_cmp_valid = 1'b0;
                    if (!r_cmp_valid && !r_hit_valid) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_cmp_valid  <= 1'b0;
            r_hit_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pool_base  <= '0;
            r_pool_bytes <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
            r_hit_valid <= n_hit_valid;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr && paddr[2] == rta_pkg::REG_POOL_BASE) begin
                r_pool_base <= pwdata;
            end
            if (w_cfg_wr && paddr[2] == rta_pkg::REG_POOL_BYTES) begin
                r_pool_bytes <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_cmp_idx <= n_cmp_idx;
        r_hit     <= n_hit;
        r_addr    <= n_addr;
        r_quo     <= n_quo;
        r_begin   <= n_begin;
        r_span    <= n_span;
        r_pg_ovf  <= n_pg_ovf;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_idx] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_idx];
        end
    end

endmodule

### src/rta_checker.sv
// port-level assertions of the region table allocator and their bind
`include "assert_macros.svh"

module rta_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_region_start,
    input logic        i_success,
    input logic [31:0] i_freed_base,
    input logic [20:0] i_freed_pages
);

    // a stalled result item holds
    `RTA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_region_start) && $stable(i_success) && $stable(i_freed_base) && $stable(i_freed_pages))

    // one item in flight at a time
    `RTA_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // an allocate result never reports freed pages
    `RTA_ASSERT_IMPLY(a_alloc_clean, i_clk, i_rst_n, i_rsp_valid && i_region_start != 32'd0, i_success && i_freed_pages == 21'd0)

    // a release result that frees pages is a success and carries no region start
    `RTA_ASSERT_IMPLY(a_release_clean, i_clk, i_rst_n, i_rsp_valid && i_freed_pages != 21'd0, i_success && i_region_start == 32'd0)

    // reset drops any pending result
    `RTA_ASSERT_NEXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, !i_rsp_valid)

endmodule

bind region_table_allocator rta_checker u_rta_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_region_start (o_rsp.region_start),
    .i_success      (o_rsp.success),
    .i_freed_base   (o_rsp.freed_base),
    .i_freed_pages  (o_rsp.freed_pages)
);

### bench/region_table_allocator_tb.sv
// self-checking bench for the region table allocator: directed table, then random phases
`timescale 1ns / 1ps

module region_table_allocator_tb;

    localparam int               PAGE_BYTES  = 4096;
    localparam int               MAX_REGIONS = 256;
    localparam logic [1:0]       KIND_NONE   = 2'd3;
    localparam logic [63:0]      ADDR_TOP    = 64'h1_0000_0000;
    localparam logic [63:0]      PAGES_MAX   = 64'h1F_FFFF;
    localparam rta_pkg::t_result NO_RESULT   = '0;
    localparam rta_pkg::t_result WANT_VALID  = '{32'h0, 1'b1, 32'h0, 21'h0};
    localparam rta_pkg::t_result WANT_FIRST  = '{32'h1000_1000, 1'b1, 32'h0, 21'h0};
    localparam rta_pkg::t_result WANT_SECOND = '{32'h1000_2000, 1'b1, 32'h0, 21'h0};

    typedef enum logic [1:0] {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} t_gap_mode;
    typedef enum logic {ROW_ITEM, ROW_POOL} t_row_op;

    // for ROW_POOL rows a is the pool base and b the pool size
    typedef struct packed {
        t_row_op          op;
        logic [1:0]       kind;
        logic [31:0]      a;
        logic [31:0]      b;
        logic             typed;
        rta_pkg::t_result want;
    } t_row;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] nbytes;
        t_gap_mode   gaps;
        int          items;
        int          w_alloc;
        int          w_rel;
        int          w_chk;
        int          wide_pct;
        int          hold;
        logic        rand_pool;
    } t_phase;

    localparam t_row DIRECTED [24] = '{
        '{ROW_ITEM, rta_pkg::KIND_ALLOC, 32'h0000_1000, 32'h0000_0000, 1'b1, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_CHECK, 32'h0000_0000, 32'h0000_0000, 1'b1, WANT_VALID},
        '{ROW_ITEM, rta_pkg::KIND_RELEASE, 32'h0000_0000, 32'h0000_0000, 1'b1, NO_RESULT},
        '{ROW_ITEM, KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NO_RESULT},
        '{ROW_POOL, KIND_NONE, 32'h1000_0000, 32'h0010_0000, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b1, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_ALLOC, 32'h0000_0001, 32'h0000_0000, 1'b1, WANT_FIRST},
        '{ROW_ITEM, rta_pkg::KIND_ALLOC, 32'h0000_1000, 32'h0000_0000, 1'b1, WANT_SECOND},
        '{ROW_ITEM, rta_pkg::KIND_ALLOC, 32'h0000_1001, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_CHECK, 32'h0000_0000, 32'h1000_0FFF, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_CHECK, 32'h0000_0000, 32'h1000_4FFF, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_CHECK, 32'h0000_0000, 32'h1000_5000, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_RELEASE, 32'h0000_0000, 32'h1000_2000, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_RELEASE, 32'h0000_0000, 32'h1000_2000, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_ALLOC, 32'h0000_2000, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_CHECK, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, NO_RESULT},
        '{ROW_POOL, KIND_NONE, 32'hFFFF_F000, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_CHECK, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_RELEASE, 32'h0000_0000, 32'h1000_1000, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_CHECK, 32'h0000_0000, 32'h1000_1000, 1'b0, NO_RESULT},
        '{ROW_ITEM, rta_pkg::KIND_ALLOC, 32'h0000_1000, 32'h0000_0000, 1'b0, NO_RESULT}
    };

    localparam t_phase PHASES [6] = '{
        '{32'h4000_0000, 32'h0020_0000, GAP_NONE, 250, 60, 20, 18, 10, 0, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, GAP_SEND, 200, 50, 25, 23, 20, 0, 1'b0},
        '{32'h8000_0000, 32'h0000_0000, GAP_BOTH, 300, 15, 70, 13, 10, 0, 1'b0},
        '{32'h0000_0000, 32'hFFFF_FFFF, GAP_RECV, 400, 85, 5, 8, 2, 0, 1'b0},
        '{32'h0123_4567, 32'h0080_0000, GAP_NONE, 350, 40, 30, 28, 10, 600, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, GAP_BOTH, 350, 40, 30, 28, 15, 0, 1'b1}
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rta_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    rta_req_if req_if ();
    rta_rsp_if rsp_if ();

    region_table_allocator #(
        .PAGE_BYTES  (PAGE_BYTES),
        .MAX_REGIONS (MAX_REGIONS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block state
    logic [31:0] pool_base_cfg;
    logic [31:0] pool_bytes_cfg;
    logic [31:0] region_base  [MAX_REGIONS];
    logic [20:0] region_pages [MAX_REGIONS];
    int          live_regions;

    rta_pkg::t_result pending_outcomes [$];
    t_gap_mode        gap_mode;
    int               hold_req;
    int               hold_left;
    int               n_errors;
    int               n_items;
    int               n_placed;
    int               n_released;
    int               n_found;
    int               n_full;
    int               peak_regions;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] span_end(input int idx);
        return 64'(region_base[idx]) + 64'(region_pages[idx]) * PAGE_BYTES;
    endfunction

    function automatic rta_pkg::t_result allocator_outcome(input logic [1:0] kind,
                                                           input logic [31:0] nbytes,
                                                           input logic [31:0] addr);
        rta_pkg::t_result res;
        logic [63:0]      pages;
        logic [63:0]      lo;
        logic [63:0]      hi;
        int               idx;
        res = '0;
        idx = 0;
        case (kind)
            rta_pkg::KIND_ALLOC: begin
                if (nbytes == 0) begin
                end else if (live_regions >= MAX_REGIONS) begin
                    n_full++;
                end else begin
                    pages = (64'(nbytes) + PAGE_BYTES - 1) / PAGE_BYTES;
                    lo = (live_regions == 0) ? 64'(pool_base_cfg) + PAGE_BYTES
                                             : span_end(live_regions - 1);
                    hi = lo + pages * PAGE_BYTES;
                    if (pages <= PAGES_MAX && hi <= ADDR_TOP &&
                            hi <= 64'(pool_base_cfg) + 64'(pool_bytes_cfg)) begin
                        region_base[live_regions]  = lo[31:0];
                        region_pages[live_regions] = pages[20:0];
                        live_regions++;
                        res.region_start = lo[31:0];
                        res.success      = (lo[31:0] != 0);
                        n_placed++;
                        if (live_regions > peak_regions) peak_regions = live_regions;
                    end
                end
            end
            rta_pkg::KIND_RELEASE: begin
                while (idx < live_regions && region_base[idx] != addr) idx++;
                if (idx < live_regions) begin
                    res.success     = 1'b1;
                    res.freed_base  = region_base[idx];
                    res.freed_pages = region_pages[idx];
                    for (int j = idx; j + 1 < live_regions; j++) begin
                        region_base[j]  = region_base[j + 1];
                        region_pages[j] = region_pages[j + 1];
                    end
                    live_regions--;
                    n_released++;
                end
            end
            rta_pkg::KIND_CHECK: begin
                if (64'(addr) >= 64'(pool_base_cfg) &&
                        64'(addr) < 64'(pool_base_cfg) + PAGE_BYTES) begin
                    res.success = 1'b1;
                end else begin
                    for (int j = 0; j < live_regions; j++) begin
                        if (64'(addr) >= 64'(region_base[j]) && 64'(addr) < span_end(j)) begin
                            res.success = 1'b1;
                            break;
                        end
                    end
                end
                if (res.success) n_found++;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == rta_pkg::REG_POOL_BASE) pool_base_cfg = val;
        else pool_bytes_cfg = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_pool(input logic [31:0] base, input logic [31:0] nbytes);
        write_reg(rta_pkg::REG_POOL_BASE, base);
        write_reg(rta_pkg::REG_POOL_BYTES, nbytes);
    endtask

    // wait until every outstanding item has come back
    task automatic settle();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_outcomes.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [31:0] nbytes,
                             input logic [31:0] addr, input logic typed,
                             input rta_pkg::t_result want);
        int               idle_pct;
        rta_pkg::t_result got;
        idle_pct = (gap_mode == GAP_SEND) ? 87 : (gap_mode == GAP_BOTH) ? 34 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.kind          <= kind;
        req_if.request_bytes <= nbytes;
        req_if.query_address <= addr;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        got = allocator_outcome(kind, nbytes, addr);
        pending_outcomes.push_back(typed ? want : got);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic draw_item(input t_phase ph, output logic [1:0] kind,
                             output logic [31:0] nbytes, output logic [31:0] addr);
        int          r;
        int          idx;
        logic [63:0] sz64;
        logic [31:0] sz;
        r = $urandom_range(0, 99);
        if (r < ph.w_alloc) kind = rta_pkg::KIND_ALLOC;
        else if (r < ph.w_alloc + ph.w_rel) kind = rta_pkg::KIND_RELEASE;
        else if (r < ph.w_alloc + ph.w_rel + ph.w_chk) kind = rta_pkg::KIND_CHECK;
        else kind = KIND_NONE;

        r = $urandom_range(0, 99);
        if (r < ph.wide_pct) begin
            nbytes = $urandom >> $urandom_range(0, 31);
        end else if (r < ph.wide_pct + 8) begin
            nbytes = 32'h0;
        end else if (r < ph.wide_pct + 16) begin
            case ($urandom_range(0, 5))
                0: nbytes = 32'h1;
                1: nbytes = PAGE_BYTES - 1;
                2: nbytes = PAGE_BYTES + 1;
                3: nbytes = 32'hFFFF_FFFF;
                4: nbytes = 32'hFFFF_F001;
                default: nbytes = PAGE_BYTES * $urandom_range(1, 8);
            endcase
        end else begin
            nbytes = $urandom_range(1, 3 * PAGE_BYTES);
        end

        r = $urandom_range(0, 99);
        idx = (live_regions > 0) ? $urandom_range(0, live_regions - 1) : 0;
        sz64 = 64'(region_pages[idx]) * PAGE_BYTES;
        sz = (sz64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sz64[31:0];
        if (kind == rta_pkg::KIND_RELEASE && live_regions > 0 && r < 75) begin
            addr = region_base[idx];
        end else if (kind == rta_pkg::KIND_RELEASE && live_regions > 0 && r < 85) begin
            addr = region_base[idx] + PAGE_BYTES;
        end else if (kind == rta_pkg::KIND_CHECK && live_regions > 0 && r < 55) begin
            case ($urandom_range(0, 4))
                0: addr = region_base[idx];
                1: addr = region_base[idx] + sz - 1;
                2: addr = region_base[idx] + sz;
                3: addr = region_base[idx] - 1;
                default: addr = region_base[idx] + $urandom_range(0, sz - 1);
            endcase
        end else if (r < 75) begin
            addr = pool_base_cfg + $urandom_range(0, 2 * PAGE_BYTES) - 1;
        end else begin
            addr = $urandom;
        end
    endtask

    // response side: stalls, long hold-off, and comparison
    initial begin
        int               stall_pct;
        rta_pkg::t_result want;
        rsp_if.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            stall_pct = (gap_mode == GAP_RECV) ? 87 : (gap_mode == GAP_BOTH) ? 34 : 0;
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                if (pending_outcomes.size() == 0) begin
                    n_errors++;
                    $display("%0t: expected no item, got start %h ok %0d base %h pages %0d",
                             $time, rsp_if.region_start, rsp_if.success,
                             rsp_if.freed_base, rsp_if.freed_pages);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (rsp_if.region_start !== want.region_start ||
                            rsp_if.success !== want.success ||
                            rsp_if.freed_base !== want.freed_base ||
                            rsp_if.freed_pages !== want.freed_pages) begin
                        n_errors++;
                        $display("%0t: expected start %h ok %0d base %h pages %0d",
                                 $time, want.region_start, want.success,
                                 want.freed_base, want.freed_pages);
                        $display("%0t:      got start %h ok %0d base %h pages %0d",
                                 $time, rsp_if.region_start, rsp_if.success,
                                 rsp_if.freed_base, rsp_if.freed_pages);
                    end
                end
            end
        end
    end

    initial begin
        logic [1:0]  kind;
        logic [31:0] nbytes;
        logic [31:0] addr;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_if.valid         = 1'b0;
        req_if.kind          = rta_pkg::KIND_ALLOC;
        req_if.request_bytes = '0;
        req_if.query_address = '0;
        gap_mode             = GAP_NONE;
        hold_req             = 0;
        pool_base_cfg        = '0;
        pool_bytes_cfg       = '0;
        live_regions         = 0;
        n_errors             = 0;
        n_items              = 0;
        n_placed             = 0;
        n_released           = 0;
        n_found              = 0;
        n_full               = 0;
        peak_regions         = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].op == ROW_POOL) begin
                settle();
                set_pool(DIRECTED[r].a, DIRECTED[r].b);
            end else begin
                send_item(DIRECTED[r].kind, DIRECTED[r].a, DIRECTED[r].b,
                          DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        foreach (PHASES[p]) begin
            settle();
            set_pool(PHASES[p].rand_pool ? $urandom : PHASES[p].base,
                     PHASES[p].rand_pool ? $urandom : PHASES[p].nbytes);
            gap_mode = PHASES[p].gaps;
            if (PHASES[p].hold > 0) hold_req = PHASES[p].hold;
            repeat (PHASES[p].items) begin
                draw_item(PHASES[p], kind, nbytes, addr);
                send_item(kind, nbytes, addr, 1'b0, NO_RESULT);
            end
        end

        settle();
        repeat (600) @(posedge i_clk);
        $display("%0d items: %0d regions placed, %0d released, %0d addresses found valid",
                 n_items, n_placed, n_released, n_found);
        $display("table peaked at %0d of %0d entries, %0d allocations refused as full",
                 peak_regions, MAX_REGIONS, n_full);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/rta_pkg.sv
src/rta_if.sv
src/region_table_allocator.sv
src/rta_checker.sv
bench/region_table_allocator_tb.sv
